@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the texture sampler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`endif
`endif

@@ hw/rtl/tws_pkg.sv @@
// Package with types, constants and helper functions of the texture sampler.
`default_nettype none
package tws_pkg;
   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;
   localparam int DEF_CHANNELS   = 3;

   localparam int SIZE_W    = 9;
   localparam int CSR_IDX_W = 2;
   localparam int PROD_W    = 42;
   localparam int IDX_W     = PROD_W - 16;
   localparam int SPLIT_HI  = 16;
   localparam int SPLIT_LO  = 8;
   localparam int RGB_W     = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_TEX_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TEX_HEIGHT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_MODE = 2'd2;

   localparam logic REQ_WRITE       = 1'b0;
   localparam logic REQ_SAMPLE      = 1'b1;
   localparam logic FILTER_NEAREST  = 1'b0;
   localparam logic FILTER_BILINEAR = 1'b1;

   typedef struct packed {
      logic               req_type;
      logic [7:0]         texel_x;
      logic [7:0]         texel_y;
      logic [7:0]         texel_red;
      logic [7:0]         texel_green;
      logic [7:0]         texel_blue;
      logic signed [31:0] u_coord;
      logic signed [31:0] v_coord;
   } tws_req_type;

   typedef struct packed {
      logic [7:0] sample_red;
      logic [7:0] sample_green;
      logic [7:0] sample_blue;
   } tws_rsp_type;

   typedef struct packed {
      logic       valid;
      logic       sample;
      logic [7:0] dx;
      logic [7:0] dy;
   } tws_ctl_type;

   typedef struct packed {
      tws_ctl_type      ctl;
      logic             wr_ok;
      logic [7:0]       wx;
      logic [7:0]       wy;
      logic [RGB_W-1:0] rgb;
   } tws_side_type;

   function automatic logic [SIZE_W-1:0] tws_mod_step(input logic [SIZE_W-1:0] r,
                                                      input logic b,
                                                      input logic [SIZE_W-1:0] n);
      logic [SIZE_W:0] t;
      begin
         t = {r, b};
         if (t >= {1'b0, n}) begin
            t = t - {1'b0, n};
         end
         return t[SIZE_W-1:0];
      end
   endfunction
endpackage
`default_nettype wire

@@ hw/rtl/wrapped_texture_sampler_top.sv @@
// Top level of the wrapped texture sampler with nearest and bilinear filtering.
// A sample request gives one result; writes give none.
// One request is accepted every cycle while req_stall is low; the four texel reads come from two dual-read copies.
// A two-entry output stage holds results while the consumer stalls.
// Synchronous reset clears the valid bits and sets the size to 256 (clamped to MAX_WIDTH/MAX_HEIGHT) and nearest mode.
// The texel memory is not cleared by reset and reads undefined until written.
`default_nettype none
`include "assert_macros.svh"
module wrapped_texture_sampler_top #(
   parameter int MAX_WIDTH  = tws_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = tws_pkg::DEF_MAX_HEIGHT,
   parameter int CHANNELS   = tws_pkg::DEF_CHANNELS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire tws_pkg::tws_req_type            req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output tws_pkg::tws_rsp_type                 rsp_data,
   input  wire logic                            csr_write,
   input  wire logic [tws_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [tws_pkg::SIZE_W-1:0]      csr_wdata
);
   import tws_pkg::*;

   localparam int XW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int YW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int ADDR_W = XW + YW;
   localparam int DATA_W = 8 * CHANNELS;

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] raw,
                                                    input int maxv);
      logic [SIZE_W-1:0] res;
      begin
         if (raw == '0) begin
            res = SIZE_W'(1);
         end else if (32'(raw) > maxv) begin
            res = SIZE_W'(maxv);
         end else begin
            res = raw;
         end
         return res;
      end
   endfunction

   function automatic logic [ADDR_W-1:0] texel_addr(input logic [SIZE_W-1:0] x,
                                                    input logic [SIZE_W-1:0] y);
      logic [15:0] xe, ye;
      begin
         xe = 16'(x);
         ye = 16'(y);
         return {ye[YW-1:0], xe[XW-1:0]};
      end
   endfunction

   logic [SIZE_W-1:0] tex_width_ff, tex_height_ff;
   logic              filter_mode_ff;

   logic en;
   logic skid_v_ff, skid_v_in, rsp_v_ff, rsp_v_in;
   tws_rsp_type skid_d_ff, skid_d_in, rsp_d_ff, rsp_d_in;

   logic                     s1_v_ff;
   tws_req_type              s1_req_ff;
   logic signed [PROD_W-1:0] s1_pu_ff, s1_pv_ff, s1_pu_in, s1_pv_in;
   logic                     s1_wok_ff, s1_wok_in;

   tws_side_type             s2_side_in, s2_side_ff;
   logic signed [IDX_W-1:0]  s2_i_in, s2_j_in, s2_i_ff, s2_j_ff;
   tws_side_type             side_ff [3];

   logic [SIZE_W-1:0] x0, y0;

   tws_ctl_type              s6_ctl_ff, s7_ctl_ff;
   logic [3:0][ADDR_W-1:0]   s6_raddr_ff, s6_raddr_in;
   logic                     s6_wen_ff;
   logic [ADDR_W-1:0]        s6_waddr_ff;
   logic [DATA_W-1:0]        s6_wdata_ff;
   logic [3:0][DATA_W-1:0]   mem_rdata;
   logic [3:0][RGB_W-1:0]    texels;

   logic        blend_v;
   tws_rsp_type blend_d;

   always_ff @(posedge clock) begin
      if (reset) begin
         tex_width_ff   <= clamp_size(SIZE_W'(256), MAX_WIDTH);
         tex_height_ff  <= clamp_size(SIZE_W'(256), MAX_HEIGHT);
         filter_mode_ff <= FILTER_NEAREST;
      end else if (csr_write) begin
         case (csr_index)
            CSR_TEX_WIDTH: begin
               tex_width_ff <= clamp_size(csr_wdata, MAX_WIDTH);
            end
            CSR_TEX_HEIGHT: begin
               tex_height_ff <= clamp_size(csr_wdata, MAX_HEIGHT);
            end
            CSR_FILTER_MODE: begin
               filter_mode_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   assign en        = !skid_v_ff;
   assign req_stall = skid_v_ff;

   assign s1_pu_in  = req_data.u_coord * $signed({1'b0, tex_width_ff});
   assign s1_pv_in  = req_data.v_coord * $signed({1'b0, tex_height_ff});
   assign s1_wok_in = ({1'b0, req_data.texel_x} < tex_width_ff) &&
                      ({1'b0, req_data.texel_y} < tex_height_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_req_ff <= req_data;
         s1_pu_ff  <= s1_pu_in;
         s1_pv_ff  <= s1_pv_in;
         s1_wok_ff <= s1_wok_in;
      end
   end

   always_comb begin
      logic signed [PROD_W-1:0] qu, qv;
      logic                     bil, inc_u, inc_v;
      bil   = (filter_mode_ff == FILTER_BILINEAR);
      qu    = bil ? s1_pu_ff - PROD_W'(32768) : s1_pu_ff;
      qv    = bil ? s1_pv_ff - PROD_W'(32768) : s1_pv_ff;
      inc_u = !bil && s1_pu_ff[PROD_W-1] && (s1_pu_ff[15:0] != '0);
      inc_v = !bil && s1_pv_ff[PROD_W-1] && (s1_pv_ff[15:0] != '0);
      s2_i_in = qu[PROD_W-1:16] + IDX_W'(inc_u);
      s2_j_in = qv[PROD_W-1:16] + IDX_W'(inc_v);
      s2_side_in.ctl.valid  = s1_v_ff;
      s2_side_in.ctl.sample = (s1_req_ff.req_type == REQ_SAMPLE);
      s2_side_in.ctl.dx     = bil ? qu[15:8] : 8'd0;
      s2_side_in.ctl.dy     = bil ? qv[15:8] : 8'd0;
      s2_side_in.wr_ok      = s1_wok_ff;
      s2_side_in.wx         = s1_req_ff.texel_x;
      s2_side_in.wy         = s1_req_ff.texel_y;
      s2_side_in.rgb        = {s1_req_ff.texel_blue, s1_req_ff.texel_green,
                               s1_req_ff.texel_red};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_side_ff <= '0;
         side_ff[0] <= '0;
         side_ff[1] <= '0;
         side_ff[2] <= '0;
      end else if (en) begin
         s2_side_ff <= s2_side_in;
         side_ff[0] <= s2_side_ff;
         side_ff[1] <= side_ff[0];
         side_ff[2] <= side_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_i_ff <= s2_i_in;
         s2_j_ff <= s2_j_in;
      end
   end

   tws_wrap u_wrap_x (
      .clock   (clock),
      .en      (en),
      .size    (tex_width_ff),
      .idx_in  (s2_i_ff),
      .rem_out (x0)
   );

   tws_wrap u_wrap_y (
      .clock   (clock),
      .en      (en),
      .size    (tex_height_ff),
      .idx_in  (s2_j_ff),
      .rem_out (y0)
   );

   always_comb begin
      logic [SIZE_W-1:0] x1, y1;
      x1 = ({1'b0, x0} + 10'd1 == {1'b0, tex_width_ff}) ? '0 : x0 + SIZE_W'(1);
      y1 = ({1'b0, y0} + 10'd1 == {1'b0, tex_height_ff}) ? '0 : y0 + SIZE_W'(1);
      s6_raddr_in[0] = texel_addr(x0, y0);
      s6_raddr_in[1] = texel_addr(x1, y0);
      s6_raddr_in[2] = texel_addr(x0, y1);
      s6_raddr_in[3] = texel_addr(x1, y1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_ctl_ff <= '0;
         s6_wen_ff <= 1'b0;
         s7_ctl_ff <= '0;
      end else if (en) begin
         s6_ctl_ff <= side_ff[2].ctl;
         s6_wen_ff <= side_ff[2].ctl.valid && !side_ff[2].ctl.sample && side_ff[2].wr_ok;
         s7_ctl_ff <= s6_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s6_raddr_ff <= s6_raddr_in;
         s6_waddr_ff <= texel_addr({1'b0, side_ff[2].wx}, {1'b0, side_ff[2].wy});
         s6_wdata_ff <= DATA_W'(side_ff[2].rgb);
      end
   end

   tws_texmem #(
      .ADDR_W (ADDR_W),
      .DATA_W (DATA_W)
   ) u_texmem (
      .clock (clock),
      .en    (en),
      .we    (s6_wen_ff && en),
      .waddr (s6_waddr_ff),
      .wdata (s6_wdata_ff),
      .raddr (s6_raddr_ff),
      .rdata (mem_rdata)
   );

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         texels[k] = mem_rdata[k][RGB_W-1:0];
      end
   end

   tws_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .ctl_in    (s7_ctl_ff),
      .texels    (texels),
      .out_valid (blend_v),
      .out_data  (blend_d)
   );

   always_comb begin
      skid_v_in = skid_v_ff;
      skid_d_in = skid_d_ff;
      rsp_v_in  = rsp_v_ff;
      rsp_d_in  = rsp_d_ff;
      if (skid_v_ff) begin
         if (!rsp_stall) begin
            rsp_d_in  = skid_d_ff;
            skid_v_in = 1'b0;
         end
      end else if (blend_v) begin
         if (rsp_v_ff && rsp_stall) begin
            skid_d_in = blend_d;
            skid_v_in = 1'b1;
         end else begin
            rsp_d_in = blend_d;
            rsp_v_in = 1'b1;
         end
      end else if (!rsp_stall) begin
         rsp_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_v_ff <= 1'b0;
         rsp_v_ff  <= 1'b0;
      end else begin
         skid_v_ff <= skid_v_in;
         rsp_v_ff  <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      skid_d_ff <= skid_d_in;
      rsp_d_ff  <= rsp_d_in;
   end

   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_d_ff;

   `ASSERT_IMPLY(a_skid_needs_out, clock, reset, skid_v_ff, rsp_v_ff, "skid full with empty output")
   `ASSERT_IMPLY(a_skid_fill_stalled, clock, reset, skid_v_ff && !$past(skid_v_ff), $past(rsp_v_ff && rsp_stall), "skid filled without stall")
   `ASSERT_CLK(a_size_range, clock, reset, tex_width_ff != '0 && tex_height_ff != '0 && 32'(tex_width_ff) <= MAX_WIDTH && 32'(tex_height_ff) <= MAX_HEIGHT, "texture size out of range")
endmodule
`default_nettype wire

@@ hw/rtl/tws_wrap.sv @@
// Three-stage pipelined reduction of a signed texel index modulo the texture size.
`default_nettype none
module tws_wrap (
   input  wire logic                         clock,
   input  wire logic                         en,
   input  wire logic [tws_pkg::SIZE_W-1:0]   size,
   input  wire logic signed [tws_pkg::IDX_W-1:0] idx_in,
   output logic [tws_pkg::SIZE_W-1:0]        rem_out
);
   import tws_pkg::*;

   logic [SIZE_W-1:0]   r1_in, r1_ff, r2_in, r2_ff, r3_in, r3_ff;
   logic [SPLIT_HI-1:0] low1_ff;
   logic [SPLIT_LO-1:0] low2_ff;

   always_comb begin
      r1_in = idx_in[IDX_W-1] ? size - SIZE_W'(1) : '0;
      for (int k = IDX_W - 2; k >= SPLIT_HI; k--) begin
         r1_in = tws_mod_step(r1_in, idx_in[k], size);
      end
   end

   always_comb begin
      r2_in = r1_ff;
      for (int k = SPLIT_HI - 1; k >= SPLIT_LO; k--) begin
         r2_in = tws_mod_step(r2_in, low1_ff[k], size);
      end
   end

   always_comb begin
      r3_in = r2_ff;
      for (int k = SPLIT_LO - 1; k >= 0; k--) begin
         r3_in = tws_mod_step(r3_in, low2_ff[k], size);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r1_ff   <= r1_in;
         low1_ff <= idx_in[SPLIT_HI-1:0];
         r2_ff   <= r2_in;
         low2_ff <= low1_ff[SPLIT_LO-1:0];
         r3_ff   <= r3_in;
      end
   end

   assign rem_out = r3_ff;
endmodule
`default_nettype wire

@@ hw/rtl/tws_texmem.sv @@
// Texel memory held as two copies, each with one write and two registered reads.
`default_nettype none
module tws_texmem #(
   parameter int ADDR_W = 16,
   parameter int DATA_W = 24
) (
   input  wire logic                   clock,
   input  wire logic                   en,
   input  wire logic                   we,
   input  wire logic [ADDR_W-1:0]      waddr,
   input  wire logic [DATA_W-1:0]      wdata,
   input  wire logic [3:0][ADDR_W-1:0] raddr,
   output logic [3:0][DATA_W-1:0]      rdata
);
   logic [DATA_W-1:0] mem_a [2**ADDR_W];
   logic [DATA_W-1:0] mem_b [2**ADDR_W];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_a[waddr] <= wdata;
         mem_b[waddr] <= wdata;
      end
      if (en) begin
         rdata[0] <= mem_a[raddr[0]];
         rdata[1] <= mem_a[raddr[1]];
         rdata[2] <= mem_b[raddr[2]];
         rdata[3] <= mem_b[raddr[3]];
      end
   end
endmodule
`default_nettype wire

@@ hw/rtl/tws_blend.sv @@
// Two-stage bilinear blend of four texels with rounding to 8-bit channels.
`default_nettype none
module tws_blend (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        en,
   input  wire tws_pkg::tws_ctl_type        ctl_in,
   input  wire logic [3:0][tws_pkg::RGB_W-1:0] texels,
   output logic                             out_valid,
   output tws_pkg::tws_rsp_type             out_data
);
   import tws_pkg::*;

   logic             v1_ff, v2_ff;
   logic [7:0]       dy1_ff;
   logic [2:0][15:0] a_in, a_ff, b_in, b_ff;
   logic [2:0][7:0]  c_in, c_ff;

   always_comb begin
      logic [8:0]  w0, w1;
      logic [16:0] ta, tb;
      w0 = 9'd256 - {1'b0, ctl_in.dx};
      w1 = {1'b0, ctl_in.dx};
      for (int k = 0; k < 3; k++) begin
         ta = 17'(texels[0][8*k +: 8]) * 17'(w0) + 17'(texels[1][8*k +: 8]) * 17'(w1);
         tb = 17'(texels[2][8*k +: 8]) * 17'(w0) + 17'(texels[3][8*k +: 8]) * 17'(w1);
         a_in[k] = ta[15:0];
         b_in[k] = tb[15:0];
      end
   end

   always_comb begin
      logic [8:0]  w0, w1;
      logic [24:0] t;
      w0 = 9'd256 - {1'b0, dy1_ff};
      w1 = {1'b0, dy1_ff};
      for (int k = 0; k < 3; k++) begin
         t = 25'(a_ff[k]) * 25'(w0) + 25'(b_ff[k]) * 25'(w1) + 25'd32768;
         c_in[k] = t[23:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= ctl_in.valid && ctl_in.sample;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff   <= a_in;
         b_ff   <= b_in;
         dy1_ff <= ctl_in.dy;
         c_ff   <= c_in;
      end
   end

   assign out_valid             = v2_ff;
   assign out_data.sample_red   = c_ff[0];
   assign out_data.sample_green = c_ff[1];
   assign out_data.sample_blue  = c_ff[2];
endmodule
`default_nettype wire

@@ dv/wrapped_texture_sampler_top_tb.sv @@
// Self-checking testbench of the wrapped texture sampler: directed table, then random phases.
`default_nettype none
module wrapped_texture_sampler_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tws_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int LATENCY_WAIT = 16;
   localparam int CYCLE_LIMIT  = 1000000;

   typedef struct {
      tws_req_type req;
      bit          typed;
      tws_rsp_type rsp;
   } table_row_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   tws_req_type          req_data;
   logic                 rsp_valid;
   logic                 rsp_stall;
   tws_rsp_type          rsp_data;
   logic                 csr_write;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [SIZE_W-1:0]    csr_wdata;

   logic [23:0]    texels [0:65535];
   int             tex_w;
   int             tex_h;
   bit             bilinear;
   tws_rsp_type    pending_samples [$];
   int             errors;
   int             cycles;
   bit             send_idle;
   bit             recv_idle;
   int             long_hold;
   table_row_type  corner_table [14];

   wrapped_texture_sampler_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic int size_of(input logic [SIZE_W-1:0] raw);
      if (raw == 0) return 1;
      if (raw > 256) return 256;
      return int'(raw);
   endfunction

   function automatic int wrap_idx(input longint k, input int n);
      longint r;
      r = k % longint'(n);
      if (r < 0) r += n;
      return int'(r);
   endfunction

   function automatic logic [23:0] texel_at(input longint i, input longint j);
      return texels[wrap_idx(j, tex_h) * 256 + wrap_idx(i, tex_w)];
   endfunction

   function automatic tws_rsp_type filter_sample(input tws_req_type r);
      longint      pu, pv, i, j;
      int          dx, dy, a, b;
      logic [23:0] t00, t10, t01, t11, res;
      pu = longint'(r.u_coord) * tex_w;
      pv = longint'(r.v_coord) * tex_h;
      if (!bilinear) begin
         res = texel_at(pu / 65536, pv / 65536);
      end else begin
         pu = pu - 32768;
         pv = pv - 32768;
         i = pu >>> 16;
         j = pv >>> 16;
         dx = int'((pu - (i <<< 16)) >> 8);
         dy = int'((pv - (j <<< 16)) >> 8);
         t00 = texel_at(i, j);
         t10 = texel_at(i + 1, j);
         t01 = texel_at(i, j + 1);
         t11 = texel_at(i + 1, j + 1);
         for (int ch = 0; ch < 3; ch++) begin
            a = int'(t00[ch*8 +: 8]) * (256 - dx) + int'(t10[ch*8 +: 8]) * dx;
            b = int'(t01[ch*8 +: 8]) * (256 - dx) + int'(t11[ch*8 +: 8]) * dx;
            res[ch*8 +: 8] = 8'((a * (256 - dy) + b * dy + 32768) >> 16);
         end
      end
      return res;
   endfunction

   function automatic tws_req_type texel_write(input int x, input int y, input logic [23:0] rgb);
      tws_req_type  r;
      logic [127:0] noise;
      noise = {$urandom, $urandom, $urandom, $urandom};
      r = noise[$bits(tws_req_type)-1:0];
      r.req_type = REQ_WRITE;
      r.texel_x = 8'(x);
      r.texel_y = 8'(y);
      {r.texel_red, r.texel_green, r.texel_blue} = rgb;
      return r;
   endfunction

   function automatic tws_req_type sample_at(input logic [31:0] u, input logic [31:0] v);
      tws_req_type  r;
      logic [127:0] noise;
      noise = {$urandom, $urandom, $urandom, $urandom};
      r = noise[$bits(tws_req_type)-1:0];
      r.req_type = REQ_SAMPLE;
      r.u_coord = u;
      r.v_coord = v;
      return r;
   endfunction

   function automatic logic [31:0] pick_coord();
      logic [31:0] pick [5] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'hFFFF};
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $urandom_range(0, 8 * 65536) - 4 * 65536;
         2: return pick[$urandom_range(0, 4)];
         default: return $urandom_range(0, 32'h1_FFFF);
      endcase
   endfunction

   task automatic send_request(input tws_req_type r, input bit typed, input tws_rsp_type rsp);
      int gap;
      gap = send_idle ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      if (r.req_type == REQ_SAMPLE) begin
         pending_samples.push_back(typed ? rsp : filter_sample(r));
      end else if (r.texel_x < tex_w && r.texel_y < tex_h) begin
         texels[int'(r.texel_y) * 256 + int'(r.texel_x)] = {r.texel_red, r.texel_green,
                                                            r.texel_blue};
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (LATENCY_WAIT) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_TEX_WIDTH: tex_w = size_of(val);
         CSR_TEX_HEIGHT: tex_h = size_of(val);
         CSR_FILTER_MODE: bilinear = val[0];
         default: ;
      endcase
   endtask

   // The receiver draws a stall length per response; a long hold is taken when one is posted.
   initial begin
      int n;
      forever begin
         n = recv_idle ? $urandom_range(0, 6) : 0;
         if (long_hold > 0) begin
            n = long_hold;
            long_hold = 0;
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      tws_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_samples.size() == 0) begin
            $error("unexpected sample result %h", rsp_data);
            errors++;
         end else begin
            want = pending_samples.pop_front();
            if (rsp_data.sample_red !== want.sample_red) begin
               $error("sample_red expected %h actual %h", want.sample_red, rsp_data.sample_red);
               errors++;
            end
            if (rsp_data.sample_green !== want.sample_green) begin
               $error("sample_green expected %h actual %h", want.sample_green,
                      rsp_data.sample_green);
               errors++;
            end
            if (rsp_data.sample_blue !== want.sample_blue) begin
               $error("sample_blue expected %h actual %h", want.sample_blue,
                      rsp_data.sample_blue);
               errors++;
            end
         end
      end
   end

   initial begin
      int          w_raw, h_raw, mixed;
      logic [23:0] rgb;
      tws_req_type r;
      errors = 0;
      cycles = 0;
      long_hold = 0;
      send_idle = 1'b0;
      recv_idle = 1'b0;
      tex_w = 256;
      tex_h = 256;
      bilinear = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_write <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Corners of the full-size texture, sampled at the extremes of the coordinate range.
      corner_table = '{
         '{texel_write(0, 0, 24'h010203), 1'b0, 24'h0},
         '{texel_write(255, 255, 24'hFFFEFD), 1'b0, 24'h0},
         '{texel_write(255, 0, 24'h102030), 1'b0, 24'h0},
         '{texel_write(0, 255, 24'h405060), 1'b0, 24'h0},
         '{sample_at(32'h0, 32'h0), 1'b1, 24'h010203},
         '{sample_at(32'h7FFF_FFFF, 32'h7FFF_FFFF), 1'b1, 24'hFFFEFD},
         '{sample_at(32'h8000_0000, 32'h8000_0000), 1'b1, 24'h010203},
         '{sample_at(32'hFFFF, 32'h0), 1'b1, 24'h102030},
         '{sample_at(32'h0, 32'hFFFF), 1'b1, 24'h405060},
         '{sample_at(32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b1, 24'h010203},
         '{sample_at(32'h7FFF_FFFF, 32'h0), 1'b1, 24'h102030},
         '{texel_write(255, 255, 24'hFFFFFF), 1'b0, 24'h0},
         '{sample_at(32'hFFFF, 32'hFFFF), 1'b1, 24'hFFFFFF},
         '{sample_at(32'hFFFF_0000, 32'h0), 1'b1, 24'h010203}
      };
      foreach (corner_table[k]) begin
         send_request(corner_table[k].req, corner_table[k].typed, corner_table[k].rsp);
      end
      drain();

      for (int p = 0; p < 16; p++) begin
         case (p)
            0: begin w_raw = 256; h_raw = 1; end
            1: begin w_raw = 1; h_raw = 511; end
            2: begin w_raw = 0; h_raw = 0; end
            3: begin w_raw = 20; h_raw = 12; end
            default: begin
               w_raw = $urandom_range(1, 8);
               h_raw = $urandom_range(1, 8);
            end
         endcase
         send_idle = (p % 4 != 1);
         recv_idle = (p % 4 != 2);
         write_csr(CSR_TEX_WIDTH, SIZE_W'(w_raw));
         write_csr(CSR_TEX_HEIGHT, SIZE_W'(h_raw));
         write_csr(CSR_FILTER_MODE, SIZE_W'((p == 1) ? 0 : (p < 4) ? 1 : $urandom_range(0, 1)));
         if (p % 5 == 0) write_csr(CSR_UNUSED, SIZE_W'($urandom));
         for (int y = 0; y < tex_h; y++) begin
            for (int x = 0; x < tex_w; x++) begin
               rgb = $urandom;
               send_request(texel_write(x, y, rgb), 1'b0, 24'h0);
            end
         end
         if (p == 5) long_hold = 300;
         mixed = (p < 4) ? 60 : 50;
         for (int k = 0; k < mixed; k++) begin
            if ($urandom_range(0, 9) < 7) begin
               r = sample_at(pick_coord(), pick_coord());
            end else if ($urandom_range(0, 1) == 0) begin
               r = texel_write($urandom_range(0, tex_w + 1), $urandom_range(0, tex_h + 1),
                               24'($urandom));
            end else begin
               r = texel_write($urandom_range(0, 255), $urandom_range(0, 255), 24'($urandom));
            end
            send_request(r, 1'b0, 24'h0);
         end
         drain();
      end

      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
`default_nettype wire

@@ wrapped_texture_sampler_top.f @@
+incdir+hw/rtl
hw/rtl/tws_pkg.sv
hw/rtl/tws_wrap.sv
hw/rtl/tws_texmem.sv
hw/rtl/tws_blend.sv
hw/rtl/wrapped_texture_sampler_top.sv
dv/wrapped_texture_sampler_top_tb.sv
